@@ hw/rtl/ilp_pkg.sv @@
`default_nettype none
// ============================================================================
// Integer literal parser package
// Shared payload types for the parser's input, result and internal queue.
// ============================================================================
package ilp_pkg;

    localparam int CHAR_WIDTH   = 8;
    localparam int NUMBER_WIDTH = 64;
    localparam int DIGIT_WIDTH  = 4;

    // One character of a literal's spelling, as it arrives on the input port.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last_char;
        logic                  empty_spelling;
    } ilp_in_t;

    // One parse result.
    typedef struct packed {
        logic                    ok;
        logic [NUMBER_WIDTH-1:0] number;
    } ilp_out_t;

    // A classified character, passed from the front end to the parse engine.
    typedef struct packed {
        logic                   is_dec;
        logic                   is_hex;
        logic                   is_x;
        logic                   is_sep;
        logic [DIGIT_WIDTH-1:0] digit;
        logic                   last_char;
        logic                   empty_spelling;
    } ilp_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/ilp_front.sv @@
`default_nettype none
// ============================================================================
// Integer literal parser front end
// Accepts characters, classifies each one and holds it in a register stage
// until the item queue takes it.
// ============================================================================
module ilp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ilp_pkg::ilp_in_t  item,
    output logic                   q_push,
    input  wire logic              q_full,
    output ilp_pkg::ilp_item_t     q_item
);
    import ilp_pkg::*;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_F  = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UP_F   = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_X  = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UNDER  = 8'h5F;
    localparam logic [CHAR_WIDTH-1:0] LOW_OFFSET  = 8'h57;
    localparam logic [CHAR_WIDTH-1:0] UP_OFFSET   = 8'h37;

    logic      stage_valid_reg;
    logic      stage_valid_next;
    ilp_item_t stage_item_reg;
    ilp_item_t classified;
    logic      accept;

    // Classify the incoming character and compute its digit value.
    always_comb
    begin
        classified                = '0;
        classified.last_char      = item.last_char;
        classified.empty_spelling = item.empty_spelling;
        classified.is_x           = (item.character == CHAR_LOW_X);
        classified.is_sep         = (item.character == CHAR_UNDER);
        if (item.character inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            classified.is_dec = 1'b1;
            classified.is_hex = 1'b1;
            classified.digit  = DIGIT_WIDTH'(item.character - CHAR_ZERO);
        end
        else if (item.character inside {[CHAR_LOW_A:CHAR_LOW_F]})
        begin
            classified.is_hex = 1'b1;
            classified.digit  = DIGIT_WIDTH'(item.character - LOW_OFFSET);
        end
        else if (item.character inside {[CHAR_UP_A:CHAR_UP_F]})
        begin
            classified.is_hex = 1'b1;
            classified.digit  = DIGIT_WIDTH'(item.character - UP_OFFSET);
        end
    end

    // The stage takes a new transaction whenever it is empty or drains this cycle.
    assign full             = stage_valid_reg && q_full;
    assign accept           = push && !full;
    assign stage_valid_next = accept || (stage_valid_reg && q_full);
    assign q_push           = stage_valid_reg;
    assign q_item           = stage_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= classified;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ilp_queue.sv @@
`default_nettype none
// ============================================================================
// Integer literal parser item queue
// Small first-in first-out buffer of classified characters between the
// front end and the parse engine.
// ============================================================================
module ilp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ilp_pkg::ilp_item_t  wr_item,
    input  wire logic                pop,
    output logic                     empty,
    output ilp_pkg::ilp_item_t       rd_item
);
    import ilp_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ilp_item_t        slots_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slots_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ilp_engine.sv @@
`default_nettype none
// ============================================================================
// Integer literal parser engine
// Applies one classified character per cycle to the parse state and builds the value with
// an overflow check; a final character needs room in the output register holding results.
// ============================================================================
module ilp_engine #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire ilp_pkg::ilp_item_t  q_item,
    output logic                     empty,
    input  wire logic                pop,
    output ilp_pkg::ilp_out_t        result
);
    import ilp_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + DIGIT_WIDTH;

    localparam logic [1:0] POS_ONE    = 2'd1;
    localparam logic [1:0] POS_MAX    = 2'd2;
    localparam logic [2:0] GROUP_SIZE = 3'd4;
    localparam logic [2:0] GROUP_MAX  = 3'd5;

    // Parse state.
    logic [1:0]             pos_reg, pos_next;
    logic                   hex_reg, hex_next;
    logic                   rej_reg, rej_next;
    logic                   sep_reg, sep_next;
    logic                   first_reg, first_next;
    logic [2:0]             group_reg, group_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    ilp_out_t               out_reg;

    logic                   ends_spelling;
    logic                   take;
    logic [PROD_W-1:0]      acc_wide;
    logic [PROD_W-1:0]      sum;
    logic                   overflow;
    logic                   good;
    logic [NUMBER_WIDTH-1:0] res_number;

    // An item that ends a spelling needs room in the result register.
    assign ends_spelling  = q_item.last_char || q_item.empty_spelling;
    assign take           = !q_empty && (!ends_spelling || !out_valid_reg || pop);
    assign q_pop          = take;
    assign out_valid_next = (take && ends_spelling) || (out_valid_reg && !pop);
    assign empty          = !out_valid_reg;
    assign result         = out_reg;

    // Multiply-add by the radix; any bit above the value width is an overflow.
    assign acc_wide = PROD_W'(acc_reg);
    assign sum      = (hex_reg ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1)))
                      + PROD_W'(q_item.digit);
    assign overflow = |sum[PROD_W-1:VALUE_WIDTH];

    // Next parse state and the result for a spelling that ends here.
    always_comb
    begin
        pos_next   = pos_reg;
        hex_next   = hex_reg;
        rej_next   = rej_reg;
        sep_next   = sep_reg;
        first_next = first_reg;
        group_next = group_reg;
        acc_next   = acc_reg;
        good       = 1'b0;
        res_number = '0;
        if (!q_item.empty_spelling)
        begin
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 2'd1;
            end
            if (!rej_reg)
            begin
                if (!hex_reg)
                begin
                    if (pos_reg == POS_ONE && q_item.is_x && acc_reg == '0)
                    begin
                        hex_next = 1'b1;
                        acc_next = '0;
                    end
                    else if (!q_item.is_dec || overflow)
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum[VALUE_WIDTH-1:0];
                    end
                end
                else if (q_item.is_sep)
                begin
                    if (group_reg == '0 || group_reg > GROUP_SIZE ||
                        (!first_reg && group_reg != GROUP_SIZE))
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        sep_next   = 1'b1;
                        first_next = 1'b0;
                        group_next = '0;
                    end
                end
                else if (!q_item.is_hex)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    if (group_reg != GROUP_MAX)
                    begin
                        group_next = group_reg + 3'd1;
                    end
                    if (overflow)
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum[VALUE_WIDTH-1:0];
                    end
                end
            end
            // A hex spelling must end with a nonempty group, a full one after a separator.
            good = !rej_next &&
                   !(hex_next && (group_next == '0 ||
                                  (sep_next && group_next != GROUP_SIZE)));
            if (good)
            begin
                res_number[VALUE_WIDTH-1:0] = acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hex_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            sep_reg       <= 1'b0;
            first_reg     <= 1'b1;
            group_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (ends_spelling)
                begin
                    pos_reg   <= '0;
                    hex_reg   <= 1'b0;
                    rej_reg   <= 1'b0;
                    sep_reg   <= 1'b0;
                    first_reg <= 1'b1;
                    group_reg <= '0;
                    acc_reg   <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    hex_reg   <= hex_next;
                    rej_reg   <= rej_next;
                    sep_reg   <= sep_next;
                    first_reg <= first_next;
                    group_reg <= group_next;
                    acc_reg   <= acc_next;
                end
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take && ends_spelling)
        begin
            out_reg.ok     <= good;
            out_reg.number <= res_number;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/integer_literal_parser.sv @@
`default_nettype none
// ============================================================================
// Integer literal parser
// Parses a decimal or 0x-prefixed hexadecimal literal, one character per
// transaction, and gives a valid flag and the value at the end of each spelling.
// ============================================================================
//
//  Channel   Handshake          Payload
//  --------  -----------------  ---------------------------------------------
//  input     push / full        item   : character, last_char, empty_spelling
//  result    pop / empty        result : ok, number
//
// One character is taken every cycle while full is low; the engine's radix
// multiply-add with overflow check runs once per cycle and sets that rate.
// An accepted last character passes through the front register, the item queue
// and the result register, in that order, before its result is offered.
// Reset empties the front register, queue and result register and returns the
// parse state to decimal with a zero value; no clearing pass follows.
// A result held with pop low stalls only items that end a spelling; other
// characters keep flowing until the queue (QUEUE_DEPTH entries) fills.
//
module integer_literal_parser #(
    parameter int VALUE_WIDTH = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ilp_pkg::ilp_in_t  item,
    output logic                   empty,
    input  wire logic              pop,
    output ilp_pkg::ilp_out_t      result
);
    import ilp_pkg::*;

    logic      q_push;
    logic      q_full;
    ilp_item_t q_wr_item;
    logic      q_pop;
    logic      q_empty;
    ilp_item_t q_rd_item;

    // Front end: classification and input register.
    ilp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_full (q_full),
        .q_item (q_wr_item)
    );

    // Queue that decouples the front end from the engine.
    ilp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .full    (q_full),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    // Back end: parse state, value accumulation and result register.
    ilp_engine #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_item  (q_rd_item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // A rejected spelling always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.ok) |-> (result.number == '0))
    else $error("rejected result carries a nonzero value");

    // A waiting result never exceeds the configured value width.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.number >> VALUE_WIDTH) == '0))
    else $error("result value exceeds the value width");

    // An accepted transaction is held in the front register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> q_push)
    else $error("accepted character lost before the queue");

    // The queue is never reported full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
    else $error("queue reports full and empty together");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Integer literal parser testbench
// Feeds decimal and 0x-prefixed hex spellings one character per transaction,
// with random bursts, gaps and result stalls. A local parse model predicts
// each result, and the checker compares every result with the oldest one due.
// ============================================================================
module tb;
    import ilp_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_REPORTS    = 20;

    localparam bit [NUMBER_WIDTH-1:0] NUMBER_MAX = '1;
    localparam bit [NUMBER_WIDTH-1:0] RADIX_DEC  = 10;
    localparam bit [NUMBER_WIDTH-1:0] RADIX_HEX  = 16;
    localparam bit [2:0]              GROUP_SIZE = 3'd4;
    localparam bit [2:0]              GROUP_SAT  = 3'd5;
    localparam bit [4:0]              NOT_DIGIT  = 5'd16;

    // ASCII codes the parser cares about.
    localparam bit [7:0] CH_ZERO    = 8'h30;
    localparam bit [7:0] CH_NINE    = 8'h39;
    localparam bit [7:0] CH_LOWER_A = 8'h61;
    localparam bit [7:0] CH_LOWER_F = 8'h66;
    localparam bit [7:0] CH_UPPER_A = 8'h41;
    localparam bit [7:0] CH_UPPER_F = 8'h46;
    localparam bit [7:0] CH_LOWER_X = 8'h78;
    localparam bit [7:0] CH_UPPER_X = 8'h58;
    localparam bit [7:0] CH_SEP     = 8'h5F;

    typedef enum int {POP_STEADY, POP_COIN, POP_RARE_STALL, POP_BURSTY} pop_mode_t;
    typedef enum int {
        MUT_REPLACE, MUT_INSERT_SEP, MUT_UPPER_X, MUT_TRAILING_SEP, MUT_DROP, MUT_NOISE
    } mutation_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     push;
    logic     full;
    ilp_in_t  item;
    logic     empty;
    logic     pop;
    ilp_out_t result;

    // Parse model state.
    bit [1:0]              lit_pos;
    bit                    lit_hex;
    bit                    lit_rejected;
    bit                    lit_sep_seen;
    bit                    lit_first_group;
    bit [2:0]              lit_group;
    bit [NUMBER_WIDTH-1:0] lit_acc;

    ilp_out_t  pending_results[$];
    bit [7:0]  spelling[$];

    pop_mode_t pop_mode = POP_STEADY;
    int        gap_max = 0;
    int        burst_left = 0;
    int        holdoff_requests = 0;
    int        holdoff_served = 0;
    int        error_count = 0;
    int        chars_sent = 0;
    int        spellings_sent = 0;
    int        results_seen = 0;
    int        results_ok = 0;
    int        idle_cycles = 0;

    integer_literal_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------

    function automatic bit [4:0] hex_digit_value(bit [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 5'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return 5'(c - CH_LOWER_A + 10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return 5'(c - CH_UPPER_A + 10);
        return NOT_DIGIT;
    endfunction

    task automatic clear_parse_state();
        lit_pos         = '0;
        lit_hex         = 1'b0;
        lit_rejected    = 1'b0;
        lit_sep_seen    = 1'b0;
        lit_first_group = 1'b1;
        lit_group       = '0;
        lit_acc         = '0;
    endtask

    // Multiply-add with overflow rejection.
    task automatic accumulate_digit(bit [4:0] d, bit [NUMBER_WIDTH-1:0] radix);
        if (lit_acc > (NUMBER_MAX - d) / radix)
            lit_rejected = 1'b1;
        else
            lit_acc = lit_acc * radix + d;
    endtask

    task automatic parse_char(input ilp_in_t it, output bit has_result, output ilp_out_t res);
        bit [1:0] pos_before;
        bit [4:0] d;
        bit       good;
        has_result = 1'b0;
        res = '0;
        // An empty spelling drops any partial one and always fails.
        if (it.empty_spelling)
        begin
            has_result = 1'b1;
            clear_parse_state();
            return;
        end
        pos_before = lit_pos;
        if (lit_pos < 2'd2)
            lit_pos++;
        d = hex_digit_value(it.character);
        if (!lit_rejected)
        begin
            if (!lit_hex)
            begin
                // A lowercase x right after a leading zero switches to hex.
                if (pos_before == 2'd1 && it.character == CH_LOWER_X && lit_acc == 0)
                begin
                    lit_hex = 1'b1;
                    lit_acc = '0;
                end
                else if (d >= RADIX_DEC)
                    lit_rejected = 1'b1;
                else
                    accumulate_digit(d, RADIX_DEC);
            end
            else if (it.character == CH_SEP)
            begin
                if (lit_group == 0 || lit_group > GROUP_SIZE ||
                    (!lit_first_group && lit_group != GROUP_SIZE))
                    lit_rejected = 1'b1;
                else
                begin
                    lit_sep_seen    = 1'b1;
                    lit_first_group = 1'b0;
                    lit_group       = '0;
                end
            end
            else if (d == NOT_DIGIT)
                lit_rejected = 1'b1;
            else
            begin
                if (lit_group < GROUP_SAT)
                    lit_group++;
                accumulate_digit(d, RADIX_HEX);
            end
        end
        // The last character closes the spelling; bare prefixes and short
        // final groups fail here.
        if (it.last_char)
        begin
            good = !lit_rejected;
            if (lit_hex && (lit_group == 0 || (lit_sep_seen && lit_group != GROUP_SIZE)))
                good = 1'b0;
            res.ok     = good;
            res.number = good ? lit_acc : '0;
            has_result = 1'b1;
            clear_parse_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one character and waits for the transaction to complete.
    // Push stays high afterward so back-to-back characters need no gap.
    task automatic send_char(bit [7:0] ch, bit last, bit drop);
        ilp_in_t  it;
        ilp_out_t res;
        bit       has_result;
        int       gap;
        it.character      = ch;
        it.last_char      = last;
        it.empty_spelling = drop;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        chars_sent++;
        parse_char(it, has_result, res);
        if (has_result)
            pending_results.push_back(res);
    endtask

    task automatic send_spelling();
        spellings_sent++;
        if (spelling.size() == 0)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        else
            for (int i = 0; i < spelling.size(); i++)
                send_char(spelling[i], i == spelling.size() - 1, 1'b0);
    endtask

    task automatic append_text(string s);
        for (int i = 0; i < s.len(); i++)
            spelling.push_back(s[i]);
    endtask

    task automatic send_text(string s);
        spelling.delete();
        append_text(s);
        send_spelling();
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_for_drain();
        push <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Spelling builders
    // ------------------------------------------------------------------

    function automatic bit [7:0] random_hex_char(bit high_only);
        bit [3:0] v;
        v = high_only ? 4'hF : 4'($urandom_range(0, 15));
        if (v < 10)
            return CH_ZERO + v;
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10;
    endfunction

    task automatic build_decimal();
        bit [NUMBER_WIDTH-1:0] v;
        spelling.delete();
        case ($urandom_range(0, 5))
            0: begin
                v = {$urandom, $urandom};
                append_text($sformatf("%0d", v));
            end
            1: begin
                v = NUMBER_MAX - $urandom_range(0, 20);
                append_text($sformatf("%0d", v));
            end
            2: append_text($sformatf("%0d", $urandom_range(0, 999)));
            3: repeat ($urandom_range(19, 22))
                spelling.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            4: begin
                repeat ($urandom_range(1, 4)) spelling.push_back(CH_ZERO);
                append_text($sformatf("%0d", $urandom));
            end
            default: begin
                // Straddles the largest value that fits.
                append_text("1844674407370955161");
                spelling.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
        endcase
    endtask

    task automatic build_hex_grouped();
        bit high_only;
        high_only = ($urandom_range(0, 4) == 0);
        spelling.delete();
        append_text("0x");
        repeat ($urandom_range(1, 4)) spelling.push_back(random_hex_char(high_only));
        repeat ($urandom_range(0, 4))
        begin
            spelling.push_back(CH_SEP);
            repeat (4) spelling.push_back(random_hex_char(high_only));
        end
    endtask

    task automatic build_hex_plain();
        bit high_only;
        high_only = ($urandom_range(0, 4) == 0);
        spelling.delete();
        append_text("0x");
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 8)) spelling.push_back(CH_ZERO);
        repeat ($urandom_range(1, 20)) spelling.push_back(random_hex_char(high_only));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_spellings();
        pop_mode = POP_COIN;
        gap_max  = 3;
        send_text("0");
        send_text("7");
        send_text("00");
        send_text("12a");
        send_text("1x");
        send_text("x");
        send_text("0x");
        send_text("0x_");
        send_text("0xaF");
        send_text("0X1");
        send_text("0x0x");
        send_text("0xg12");
        send_text("0x1_");
        send_text("0x_1");
        send_text("0x1__2345");
        send_text("0x1_abcd");
        send_text("0x12345_6789");
        send_text("0x1_23");
        // Character extremes, alone and after a digit.
        spelling.delete();
        spelling.push_back(8'h00);
        send_spelling();
        spelling.delete();
        spelling.push_back(8'hFF);
        send_spelling();
        spelling.delete();
        spelling.push_back(CH_NINE);
        spelling.push_back(8'hFF);
        send_spelling();
        // Empty spelling, both with and without last_char, and mid-spelling.
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
        send_char(CH_ZERO, 1'b0, 1'b0);
        send_char(CH_LOWER_X, 1'b0, 1'b0);
        send_char(8'hA5, 1'b1, 1'b1);
    endtask

    task automatic test_decimal_values(int budget);
        int stop_at;
        pop_mode = POP_STEADY;
        gap_max  = 0;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            build_decimal();
            send_spelling();
        end
    endtask

    task automatic test_hex_grouped(int budget);
        int stop_at;
        pop_mode = POP_BURSTY;
        gap_max  = 6;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            build_hex_grouped();
            send_spelling();
        end
    endtask

    task automatic test_hex_plain(int budget);
        int stop_at;
        pop_mode = POP_RARE_STALL;
        gap_max  = 2;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            build_hex_plain();
            send_spelling();
        end
    endtask

    // Well-formed spellings broken in one place, plus pure noise.
    task automatic test_malformed_spellings(int budget);
        int        stop_at;
        int        pos;
        mutation_t kind;
        pop_mode = POP_COIN;
        gap_max  = 8;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            case ($urandom_range(0, 2))
                0: build_decimal();
                1: build_hex_grouped();
                default: build_hex_plain();
            endcase
            kind = mutation_t'($urandom_range(0, 5));
            pos  = $urandom_range(0, spelling.size() - 1);
            case (kind)
                MUT_REPLACE:      spelling[pos] = 8'($urandom_range(0, 255));
                MUT_INSERT_SEP:   spelling.insert(pos, CH_SEP);
                MUT_UPPER_X:      spelling[1] = CH_UPPER_X;
                MUT_TRAILING_SEP: spelling.push_back(CH_SEP);
                MUT_DROP:         spelling.delete(pos);
                default:
                begin
                    spelling.delete();
                    repeat ($urandom_range(1, 8))
                        spelling.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_spelling();
        end
    endtask

    // Partial spellings cut short by an empty-spelling transaction.
    task automatic test_dropped_spellings(int budget);
        int stop_at;
        int cut;
        pop_mode = POP_BURSTY;
        gap_max  = 4;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 1))
                build_decimal();
            else
                build_hex_grouped();
            cut = $urandom_range(0, spelling.size() - 1);
            for (int i = 0; i < cut; i++)
                send_char(spelling[i], 1'b0, 1'b0);
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            spellings_sent++;
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills and pushes back on its input.
    task automatic test_input_backpressure(int budget);
        int stop_at;
        pop_mode = POP_STEADY;
        gap_max  = 0;
        stop_at  = chars_sent + budget;
        holdoff_requests++;
        while (chars_sent < stop_at)
        begin
            build_decimal();
            send_spelling();
        end
    endtask

    // Short rounds, each followed by a full drain of the results.
    task automatic test_drain_pauses(int budget);
        int stop_at;
        pop_mode = POP_COIN;
        gap_max  = 3;
        stop_at  = chars_sent + budget;
        while (chars_sent < stop_at)
        begin
            repeat ($urandom_range(1, 3))
            begin
                build_hex_grouped();
                send_spelling();
            end
            wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern, with a long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int holdoff_left;
        int phase;
        holdoff_left = 0;
        phase = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_requests != holdoff_served)
            begin
                holdoff_served = holdoff_requests;
                holdoff_left   = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (pop_mode)
                    POP_STEADY:     pop <= 1'b1;
                    POP_COIN:       pop <= 1'($urandom_range(0, 1));
                    POP_RARE_STALL: pop <= ($urandom_range(0, 7) != 0);
                    default:        pop <= ((phase % 11) < 6);
                endcase
            end
            phase++;
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result transaction against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        ilp_out_t want;
        if (pop && !empty)
        begin
            results_seen++;
            if (result.ok === 1'b1)
                results_ok++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual ok=%b number=%h",
                             $time, result.ok, result.number);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.ok !== want.ok)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: ok mismatch: expected %b, actual %b",
                                 $time, want.ok, result.ok);
                end
                if (result.number !== want.number)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: number mismatch: expected %h, actual %h",
                                 $time, want.number, result.number);
                end
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge clk)
    begin : progress_watchdog
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("integer_literal_parser verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        rst_n <= 1'b0;
        push  <= 1'b0;
        item  <= '0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_spellings();
        test_decimal_values(200);
        test_hex_grouped(300);
        test_hex_plain(200);
        test_malformed_spellings(300);
        test_dropped_spellings(100);
        test_input_backpressure(100);
        test_drain_pauses(100);

        wait_for_drain();
        $display("Sent %0d characters in %0d spellings; checked %0d results, %0d valid.",
                 chars_sent, spellings_sent, results_seen, results_ok);
        $display("Covered decimal and hex overflow edges, grouped and malformed hex, %s",
                 "dropped spellings, a long result hold-off and drain pauses.");
        if (error_count == 0)
            $display("integer_literal_parser verification clean");
        else
            $display("integer_literal_parser verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_front.sv
hw/rtl/ilp_queue.sv
hw/rtl/ilp_engine.sv
hw/rtl/integer_literal_parser.sv
bench/tb.sv
